@@ src/b64enc_pkg.sv @@
package b64enc_pkg;

   localparam int SYM_W     = 7;
   localparam int SLOTS     = 4;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = $clog2(Q_DEPTH);

   localparam logic [SYM_W-1:0] PAD_CHAR = 7'h3D;

   typedef logic [SYM_W-1:0] sym_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   // one queue entry: the characters caused by one input byte
   typedef struct packed {
      sym_type [SLOTS-1:0] syms;
      logic [SLOT_W-1:0]   last_idx;
      logic                eot;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic sym_type encode(input logic [5:0] six);
      sym_type sym;
      case (six) inside
         [6'd0:6'd25]:  sym = SYM_W'(7'h41 + 7'(six));
         [6'd26:6'd51]: sym = SYM_W'(7'h61 + 7'(six) - 7'd26);
         [6'd52:6'd61]: sym = SYM_W'(7'h30 + 7'(six) - 7'd52);
         6'd62:         sym = 7'h2B;
         default:       sym = 7'h2F;
      endcase
      return sym;
   endfunction

endpackage

@@ src/b64enc_front.sv @@
module b64enc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_final_byte,
   input  b64enc_pkg::q_status_type q_status,
   output logic                    req_ready,
   output logic                    push,
   output b64enc_pkg::entry_type   push_entry
);
   import b64enc_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         carry_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

   always_comb begin
      phase_in            = phase_ff;
      carry_in            = carry_ff;
      push_entry.syms     = {SLOTS{PAD_CHAR}};
      push_entry.last_idx = '0;
      push_entry.eot      = req_final_byte;
      case (phase_ff)
         PH_SECOND: begin
            push_entry.syms[0] = encode({carry_ff[1:0], req_data_byte[7:4]});
            if (req_final_byte) begin
               push_entry.syms[1]  = encode({req_data_byte[3:0], 2'b00});
               push_entry.last_idx = SLOT_W'(2);
            end
            if (push) begin
               phase_in = req_final_byte ? PH_FIRST : PH_THIRD;
               carry_in = req_final_byte ? 4'd0 : req_data_byte[3:0];
            end
         end
         PH_THIRD: begin
            push_entry.syms[0]  = encode({carry_ff, req_data_byte[7:6]});
            push_entry.syms[1]  = encode(req_data_byte[5:0]);
            push_entry.last_idx = SLOT_W'(1);
            if (push) begin
               phase_in = PH_FIRST;
               carry_in = '0;
            end
         end
         default: begin
            push_entry.syms[0] = encode(req_data_byte[7:2]);
            if (req_final_byte) begin
               push_entry.syms[1]  = encode({req_data_byte[1:0], 4'b0000});
               push_entry.last_idx = SLOT_W'(3);
            end
            if (push) begin
               phase_in = req_final_byte ? PH_FIRST : PH_SECOND;
               carry_in = req_final_byte ? 4'd0 : {2'b00, req_data_byte[1:0]};
            end
         end
      endcase
   end

endmodule

@@ src/b64enc_queue.sv @@
module b64enc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64enc_pkg::entry_type    push_entry,
   input  logic                     pop,
   output b64enc_pkg::entry_type    head,
   output b64enc_pkg::q_status_type q_status
);
   import b64enc_pkg::*;

   entry_type       mem [Q_DEPTH];
   logic [Q_AW:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]   fill;

   assign fill           = wr_ptr_ff - rd_ptr_ff;
   assign q_status.full  = (fill == (Q_AW+1)'(Q_DEPTH));
   assign q_status.empty = (fill == '0);
   assign head           = mem[rd_ptr_ff[Q_AW-1:0]];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff[Q_AW-1:0]] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty) else $error("queue pop while empty");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= (Q_AW+1)'(Q_DEPTH)) else $error("queue fill out of range");
`endif

endmodule

@@ src/b64enc_back.sv @@
module b64enc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64enc_pkg::entry_type    head,
   input  b64enc_pkg::q_status_type q_status,
   input  logic                     rsp_ready,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic [6:0]               rsp_symbol,
   output logic                     rsp_end_of_text
);
   import b64enc_pkg::*;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   sym_type           sym_ff, sym_in;
   logic              eot_ff, eot_in;
   logic              load;
   logic              at_last;

   assign load      = !q_status.empty && (!valid_ff || rsp_ready);
   assign at_last   = (idx_ff == head.last_idx);
   assign pop       = load && at_last;

   assign rsp_valid       = valid_ff;
   assign rsp_symbol      = sym_ff;
   assign rsp_end_of_text = eot_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      sym_in   = sym_ff;
      eot_in   = eot_ff;
      if (load) begin
         valid_in = 1'b1;
         sym_in   = head.syms[idx_ff];
         eot_in   = at_last && head.eot;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      eot_ff <= eot_in;
   end

endmodule

@@ src/base64_stream_encoder.sv @@
// Base64 encoder (standard alphabet, '=' padding). One byte is taken per req beat; a front
// stage turns it into its one to four characters and queues them (four entries), and the
// back stage sends one character per rsp beat from a registered output. The output side
// sets the pace: a byte holds the back stage until all of its characters are sent: two for
// the third byte of a group, one for other non-final bytes, up to four on the flush of a
// final byte, so a long stream yields four characters per three bytes. The input keeps
// flowing while the queue has room. The last character of a message carries
// rsp_end_of_text.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_symbol,
   output logic       rsp_end_of_text
);
   import b64enc_pkg::*;

   entry_type    push_entry;
   entry_type    head;
   q_status_type q_status;
   logic         push;
   logic         pop;

   b64enc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_status       (q_status),
      .req_ready      (req_ready),
      .push           (push),
      .push_entry     (push_entry)
   );

   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   b64enc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .rsp_ready       (rsp_ready),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol),
      .rsp_end_of_text (rsp_end_of_text)
   );

endmodule

@@ sim/b64_char_checker.sv @@
`timescale 1ns / 100ps

module b64_char_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [6:0] rsp_symbol,
   input  logic       rsp_end_of_text,
   output int         err_count,
   output int         pending
);
   import b64enc_pkg::*;

   typedef struct packed {
      sym_type symbol;
      logic    eot;
   } char_beat_type;

   string         alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   phase_type     group_pos = PH_FIRST;
   logic [3:0]    leftover = 4'd0;
   char_beat_type chars_due[$];

   initial begin
      err_count = 0;
      pending   = 0;
   end

   function automatic sym_type b64_char(input logic [5:0] six);
      return sym_type'(alphabet[six]);
   endfunction

   task automatic queue_char(input sym_type sym, input logic eot);
      char_beat_type c;
      c.symbol = sym;
      c.eot    = eot;
      chars_due.push_back(c);
   endtask

   // characters a byte produces, in order; updates group position and leftover bits
   task automatic predict_chars(input logic [7:0] b, input logic fin);
      case (group_pos)
         PH_SECOND: begin
            queue_char(b64_char({leftover[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               queue_char(b64_char({b[3:0], 2'b00}), 1'b0);
               queue_char(PAD_CHAR, 1'b1);
               group_pos = PH_FIRST;
               leftover  = 4'd0;
            end else begin
               leftover  = b[3:0];
               group_pos = PH_THIRD;
            end
         end
         PH_THIRD: begin
            queue_char(b64_char({leftover, b[7:6]}), 1'b0);
            queue_char(b64_char(b[5:0]), fin);
            group_pos = PH_FIRST;
            leftover  = 4'd0;
         end
         default: begin
            queue_char(b64_char(b[7:2]), 1'b0);
            if (fin) begin
               queue_char(b64_char({b[1:0], 4'b0000}), 1'b0);
               queue_char(PAD_CHAR, 1'b0);
               queue_char(PAD_CHAR, 1'b1);
               group_pos = PH_FIRST;
               leftover  = 4'd0;
            end else begin
               leftover  = {2'b00, b[1:0]};
               group_pos = PH_SECOND;
            end
         end
      endcase
   endtask

   task automatic note_mismatch(input string what, input char_beat_type exp_c,
                                input char_beat_type act_c);
      err_count++;
      if (err_count <= 10)
         $display("%0t: %s: expected symbol %h eot %b, got symbol %h eot %b",
                  $realtime, what, exp_c.symbol, exp_c.eot, act_c.symbol, act_c.eot);
   endtask

   always @(posedge clock) begin
      char_beat_type got;
      char_beat_type want;
      if (reset) begin
         group_pos = PH_FIRST;
         leftover  = 4'd0;
         chars_due.delete();
      end else begin
         if (req_valid && req_ready)
            predict_chars(req_data_byte, req_final_byte);
         if (rsp_valid && rsp_ready) begin
            got.symbol = rsp_symbol;
            got.eot    = rsp_end_of_text;
            if (chars_due.size() == 0) begin
               want = '0;
               note_mismatch("unexpected rsp beat", want, got);
            end else begin
               want = chars_due.pop_front();
               if (got.symbol !== want.symbol || got.eot !== want.eot)
                  note_mismatch("rsp mismatch", want, got);
            end
         end
      end
      pending = chars_due.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import b64enc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BYTES = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_symbol;
   logic       rsp_end_of_text;
   int         err_count;
   int         pending;

   int         cycles = 0;
   int         beats_sent = 0;
   int         burst_left = 0;
   int         stall_mode = 0;
   int         mode_left = 0;
   int         hold_left = 0;
   logic       hold_done = 1'b0;

   base64_stream_encoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_symbol(rsp_symbol), .rsp_end_of_text(rsp_end_of_text)
   );

   b64_char_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_final_byte(req_final_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_symbol(rsp_symbol), .rsp_end_of_text(rsp_end_of_text),
      .err_count(err_count), .pending(pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stall patterns, plus one long hold-off to back up the queue
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && beats_sent >= 40) begin
         hold_done <= 1'b1;
         hold_left <= 80;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(8, 40);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // one req beat; sender may idle between bursts of random length
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      beats_sent++;
   endtask

   initial begin
      int sent;
      int len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-byte messages at the extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // two-byte messages
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      // full groups: all '+', all 'A', then four bytes ending mid-group, then 'Man'
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
         sent += len;
      end
      req_valid      <= 1'b0;
      req_final_byte <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder.sv
sim/b64_char_checker.sv
sim/tb.sv
